[rtl/core/frame_sequence_checker_defines.svh]
// Assertion macros for the frame sequence checker RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FRAME_SEQUENCE_CHECKER_DEFINES_SVH
`define FRAME_SEQUENCE_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset
`define FSC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("frame sequence checker assertion failed");

// Condition that must never be true outside reset
`define FSC_ASSERT_NEVER(name, clk, rst, cond) \
  `FSC_ASSERT(name, clk, rst, !(cond))

`else

`define FSC_ASSERT(name, clk, rst, prop)
`define FSC_ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

[rtl/core/fsc_pkg.sv]
// Shared types and constants for the frame sequence checker.
// No dependencies; used by every module of the block.
`default_nettype none

package fsc_pkg;

  // Field widths
  localparam int IDENT_W  = 29;
  localparam int LEN_W    = 4;
  localparam int FLAGS_W  = 8;
  localparam int WORD_W   = 32;
  localparam int MASK_W   = 5;

  // Stream widths: used bits and byte-padded bus widths
  localparam int IN_USED_W  = IDENT_W + LEN_W + FLAGS_W + 2 * WORD_W;
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W = MASK_W + 11 * WORD_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_WORD  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT  = 4'd3;

  // Reset values of the configuration registers
  localparam logic [IDENT_W-1:0] FRAME_ID_RST  = 29'h100;
  localparam logic [LEN_W-1:0]   LENGTH_RST    = 4'd8;
  localparam logic [WORD_W-1:0]  TAIL_WORD_RST = 32'h3412_55AA; // bytes AA 55 12 34
  localparam logic [WORD_W-1:0]  GAP_LIMIT_RST = 32'd500000;

  // Bit positions in the error mask
  localparam int ERR_SEQ    = 0;
  localparam int ERR_IDENT  = 1;
  localparam int ERR_LENGTH = 2;
  localparam int ERR_FLAGS  = 3;
  localparam int ERR_TAIL   = 4;

  // One input item; last field sits in the lowest bits
  typedef struct packed {
    logic [WORD_W-1:0]  tail_word;
    logic [WORD_W-1:0]  sequence_word;
    logic [FLAGS_W-1:0] frame_flag_bits;
    logic [LEN_W-1:0]   frame_length_code;
    logic [IDENT_W-1:0] frame_ident;
  } frame_t;

  // Configuration registers
  typedef struct packed {
    logic [IDENT_W-1:0] expected_frame_id;
    logic [LEN_W-1:0]   expected_length_code;
    logic [WORD_W-1:0]  expected_tail_word;
    logic [WORD_W-1:0]  gap_limit;
  } cfg_t;

  // Classified frame handed from the check stage to the tally stage
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [WORD_W-1:0] expected_seq;
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] gap;
    logic              forward;
    logic              backward;
  } event_t;

  // Running totals
  typedef struct packed {
    logic [WORD_W-1:0] checked;
    logic [WORD_W-1:0] sequence_err;
    logic [WORD_W-1:0] missing;
    logic [WORD_W-1:0] jump;
    logic [WORD_W-1:0] backward;
    logic [WORD_W-1:0] ident_err;
    logic [WORD_W-1:0] length_err;
    logic [WORD_W-1:0] flag_err;
    logic [WORD_W-1:0] tail_err;
  } tally_t;

  // One result item; last field sits in the lowest bits
  typedef struct packed {
    logic [WORD_W-1:0] tail_error_total;
    logic [WORD_W-1:0] flag_error_total;
    logic [WORD_W-1:0] length_error_total;
    logic [WORD_W-1:0] ident_error_total;
    logic [WORD_W-1:0] backward_total;
    logic [WORD_W-1:0] large_jump_total;
    logic [WORD_W-1:0] missing_frame_total;
    logic [WORD_W-1:0] sequence_error_total;
    logic [WORD_W-1:0] frames_checked;
    logic [WORD_W-1:0] first_sequence;
    logic [WORD_W-1:0] expected_seq;
    logic [MASK_W-1:0] error_mask;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/fsc_cfg_regs.sv]
// Configuration register file of the frame sequence checker.
// Depends on fsc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module fsc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [fsc_pkg::WORD_W-1:0]     wr_data,
  output fsc_pkg::cfg_t                  cfg
);
  import fsc_pkg::*;

  cfg_t regs;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_frame_id    <= FRAME_ID_RST;
      regs.expected_length_code <= LENGTH_RST;
      regs.expected_tail_word   <= TAIL_WORD_RST;
      regs.gap_limit            <= GAP_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FRAME_ID:  regs.expected_frame_id    <= wr_data[IDENT_W-1:0];
        REG_LENGTH:    regs.expected_length_code <= wr_data[LEN_W-1:0];
        REG_TAIL_WORD: regs.expected_tail_word   <= wr_data;
        REG_GAP_LIMIT: regs.gap_limit            <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

[rtl/core/fsc_classify.sv]
// Check stage: tracks the expected counter and classifies each frame.
// Depends on fsc_pkg for frame_t, cfg_t, event_t and the error bit positions.
`default_nettype none

module fsc_classify (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  fsc_pkg::frame_t frame,
  input  fsc_pkg::cfg_t   cfg,
  input  logic            advance,
  output logic            ev_valid,
  output fsc_pkg::event_t ev
);
  import fsc_pkg::*;

  logic              seeded;
  logic [WORD_W-1:0] next_expected;
  logic [WORD_W-1:0] first_seen;

  logic              fire;
  logic [WORD_W-1:0] seq;
  logic [WORD_W-1:0] expect_seq;
  event_t            ev_next;

  assign fire = in_valid && advance;
  assign seq  = frame.sequence_word;

  // First frame seeds the expectation with its own counter
  assign expect_seq = seeded ? next_expected : seq;

  // Classify counter and compare the fixed fields
  always_comb begin
    ev_next.mask             = '0;
    ev_next.mask[ERR_SEQ]    = (seq != expect_seq);
    ev_next.mask[ERR_IDENT]  = (frame.frame_ident != cfg.expected_frame_id);
    ev_next.mask[ERR_LENGTH] = (frame.frame_length_code != cfg.expected_length_code);
    ev_next.mask[ERR_FLAGS]  = (frame.frame_flag_bits != '0);
    ev_next.mask[ERR_TAIL]   = (frame.tail_word != cfg.expected_tail_word);
    ev_next.expected_seq     = expect_seq;
    ev_next.first            = seeded ? first_seen : seq;
    ev_next.gap              = seq - expect_seq;
    ev_next.forward          = (seq > expect_seq);
    ev_next.backward         = (seq < expect_seq);
  end

  // Sequence tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded        <= 1'b0;
      next_expected <= '0;
      first_seen    <= '0;
    end else if (fire) begin
      seeded        <= 1'b1;
      next_expected <= seq + 32'd1;
      first_seen    <= ev_next.first;
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (advance) begin
      ev_valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (fire) begin
      ev <= ev_next;
    end
  end

  `include "frame_sequence_checker_defines.svh"

  `FSC_ASSERT(a_seeded_after_frame, clk, rst, fire |=> seeded)
  `FSC_ASSERT(a_first_frame_in_sequence, clk, rst, (fire && !seeded) |=> !ev.mask[ERR_SEQ])
  `FSC_ASSERT(a_resync, clk, rst, fire |=> (next_expected == $past(seq) + 32'd1))

endmodule

`default_nettype wire

[rtl/core/fsc_tally.sv]
// Tally stage: accumulates the error counters from classified frames.
// Depends on fsc_pkg for event_t, tally_t, result_t and the error bit positions.
`default_nettype none

module fsc_tally (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  fsc_pkg::event_t            ev,
  input  logic [fsc_pkg::WORD_W-1:0] gap_limit,
  output fsc_pkg::result_t           res
);
  import fsc_pkg::*;

  tally_t            totals;
  tally_t            totals_next;
  logic              in_limit;
  logic [WORD_W-1:0] missing_sum;

  // Gap compare and sum run side by side, then select
  assign in_limit    = (ev.gap <= gap_limit);
  assign missing_sum = totals.missing + ev.gap;

  always_comb begin
    totals_next.checked      = totals.checked + 32'd1;
    totals_next.sequence_err = totals.sequence_err + WORD_W'(ev.mask[ERR_SEQ]);
    totals_next.missing      = (ev.forward && in_limit) ? missing_sum : totals.missing;
    totals_next.jump         = totals.jump + WORD_W'(ev.forward && !in_limit);
    totals_next.backward     = totals.backward + WORD_W'(ev.backward);
    totals_next.ident_err    = totals.ident_err + WORD_W'(ev.mask[ERR_IDENT]);
    totals_next.length_err   = totals.length_err + WORD_W'(ev.mask[ERR_LENGTH]);
    totals_next.flag_err     = totals.flag_err + WORD_W'(ev.mask[ERR_FLAGS]);
    totals_next.tail_err     = totals.tail_err + WORD_W'(ev.mask[ERR_TAIL]);
  end

  // Counters, wrapping modulo 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      totals <= '0;
    end else if (fire) begin
      totals <= totals_next;
    end
  end

  // Result item for this frame
  always_comb begin
    res.error_mask           = ev.mask;
    res.expected_seq         = ev.expected_seq;
    res.first_sequence       = ev.first;
    res.frames_checked       = totals_next.checked;
    res.sequence_error_total = totals_next.sequence_err;
    res.missing_frame_total  = totals_next.missing;
    res.large_jump_total     = totals_next.jump;
    res.backward_total       = totals_next.backward;
    res.ident_error_total    = totals_next.ident_err;
    res.length_error_total   = totals_next.length_err;
    res.flag_error_total     = totals_next.flag_err;
    res.tail_error_total     = totals_next.tail_err;
  end

  `include "frame_sequence_checker_defines.svh"

  `FSC_ASSERT(a_checked_counts, clk, rst, fire |=> (totals.checked == $past(totals.checked) + 32'd1))
  `FSC_ASSERT(a_totals_hold, clk, rst, !fire |=> $stable(totals))

endmodule

`default_nettype wire

[rtl/core/frame_sequence_checker.sv]
// Frame sequence checker: input register, check stage, tally stage, result register.
// A result passes the input, check-stage and result registers before it is offered.
// One item per cycle while m_axis_tready is high; a stage moves when the next frees.
// Sync reset restores config defaults, clears all tallies and the seeded flag.
// Depends on fsc_pkg, fsc_cfg_regs, fsc_classify and fsc_tally.
`default_nettype none

module frame_sequence_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // frame_ident, frame_length_code, frame_flag_bits, sequence_word, tail_word
  input  logic [fsc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // error_mask, expected_seq, first_sequence, frames_checked,
  // sequence_error_total, missing_frame_total, large_jump_total, backward_total,
  // ident_error_total, length_error_total, flag_error_total, tail_error_total
  output logic [fsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fsc_pkg::WORD_W-1:0]        cfg_data
);
  import fsc_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  frame_t  in_frame;
  logic    ev_valid;
  event_t  ev;
  logic    out_valid;
  result_t out_result;
  result_t res;
  logic    adv_check;
  logic    adv_out;

  // Stage handshakes: each register loads when it is empty or draining
  assign adv_out       = !out_valid || m_axis_tready;
  assign adv_check     = !ev_valid || adv_out;
  assign s_axis_tready = !in_valid || adv_check;
  assign cfg_ready     = 1'b1;

  fsc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_frame <= frame_t'(s_axis_tdata[IN_USED_W-1:0]);
    end
  end

  fsc_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .frame    (in_frame),
    .cfg      (cfg),
    .advance  (adv_check),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  fsc_tally u_tally (
    .clk       (clk),
    .rst       (rst),
    .fire      (ev_valid && adv_out),
    .ev        (ev),
    .gap_limit (cfg.gap_limit),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && adv_out) begin
      out_result <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_result};

endmodule

`default_nettype wire
